// ===== hdl/mthps_pkg.sv =====
// ----------------------------------------------------------------------------
// mthps_pkg
// Shared types and constants of the muon track hit-pattern selector.
// ----------------------------------------------------------------------------
package mthps_pkg;

    // Default geometry of the muon system
    localparam int NUM_STATIONS_DEF = 5;
    localparam int NUM_REGIONS_DEF  = 4;

    // Field widths
    localparam int STATION_W  = 3;
    localparam int REGION_W   = 2;
    localparam int QUARTER_W  = 2;
    localparam int MOM_W      = 20;
    localparam int CHI2_W     = 16;
    localparam int CALO_W     = 16;
    localparam int MIN_ST_W   = 4;
    localparam int RMODE_W    = 7;
    localparam int OUT_CNT_W  = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM_CUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STATIONS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_OVERLAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CALO_CHECK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHI2_CUT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_MODE  = 3'd5;

    // Request codes
    localparam logic REQ_HIT   = 1'b0;
    localparam logic REQ_CLOSE = 1'b1;

    // Calorimeter acceptance, positions at z = 12750 mm
    localparam logic signed [CALO_W-1:0] CALO_X_LIMIT_MM = 16'sd3900;
    localparam logic signed [CALO_W-1:0] CALO_Y_LIMIT_MM = 16'sd3150;

    // Region mode codes
    localparam logic signed [RMODE_W-1:0] RMODE_OFF       = -7'sd1;
    localparam logic signed [RMODE_W-1:0] RMODE_SINGLE_HI = 7'sd3;
    localparam logic signed [RMODE_W-1:0] RMODE_ONE       = 7'sd10;
    localparam logic signed [RMODE_W-1:0] RMODE_TENS_2    = 7'sd20;
    localparam logic signed [RMODE_W-1:0] RMODE_TENS_3    = 7'sd30;
    localparam logic signed [RMODE_W-1:0] RMODE_TENS_END  = 7'sd40;

    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = 3'd7;
    localparam logic [MIN_ST_W-1:0]  MIN_ST_RST  = 4'd2;

    typedef struct packed {
        logic                       req_type;
        logic                       hit_is_muon;
        logic [STATION_W-1:0]       hit_station;
        logic [REGION_W-1:0]        hit_region;
        logic [QUARTER_W-1:0]       hit_quarter;
        logic [MOM_W-1:0]           momentum_mev;
        logic [CHI2_W-1:0]          chi2_per_dof_q8;
        logic signed [CALO_W-1:0]   calo_x_mm;
        logic signed [CALO_W-1:0]   calo_y_mm;
    } t_in_item;

    typedef struct packed {
        logic                       track_selected;
        logic [OUT_CNT_W-1:0]       a_side_stations;
        logic [OUT_CNT_W-1:0]       c_side_stations;
    } t_out_item;

    typedef struct packed {
        logic [MOM_W-1:0]           momentum_cut_mev;
        logic [MIN_ST_W-1:0]        min_stations;
        logic                       no_overlap_enable;
        logic                       calo_check_enable;
        logic [CHI2_W-1:0]          chi2_cut_q8;
        logic signed [RMODE_W-1:0]  region_mode;
    } t_cfg;

endpackage

// ===== hdl/muon_track_hit_pattern_selector_core.sv =====
// ----------------------------------------------------------------------------
// muon_track_hit_pattern_selector_core
// Collects the muon hit pattern of a track and applies the selection cuts.
// ----------------------------------------------------------------------------
// A track arrives as a run of hit items followed by one closing item. Every
// item is held in the input register and is then consumed: a muon hit
// sets its station bit (A side for quarters 0-1, C side for quarters 2-3) and
// its region bit, a closing item is evaluated against the configured cuts
// and its result is written to the output register, after which the hit
// masks are cleared for the next track. The block takes one item per cycle,
// and a closing item goes through the input and then the output register;
// throughput drops only while a finished result sits stalled in the output
// register and a closing item is waiting behind it. Hit items never produce
// a result. Configuration registers are written through the plain write port
// and must only change while no track is in flight.
module muon_track_hit_pattern_selector_core #(
    parameter int NUM_STATIONS = mthps_pkg::NUM_STATIONS_DEF,
    parameter int NUM_REGIONS  = mthps_pkg::NUM_REGIONS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input items
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  mthps_pkg::t_in_item                   i_data,
    // result items
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output mthps_pkg::t_out_item                  o_data,
    // configuration
    input  logic                                  i_cfg_wr_en,
    input  logic [mthps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mthps_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    mthps_pkg::t_cfg        r_cfg;
    mthps_pkg::t_cfg        n_cfg;
    logic                   r_in_vld;
    logic                   n_in_vld;
    mthps_pkg::t_in_item    r_in;
    logic [NUM_STATIONS-1:0] r_a_mask;
    logic [NUM_STATIONS-1:0] n_a_mask;
    logic [NUM_STATIONS-1:0] r_c_mask;
    logic [NUM_STATIONS-1:0] n_c_mask;
    logic [NUM_REGIONS-1:0]  r_region_mask;
    logic [NUM_REGIONS-1:0]  n_region_mask;
    logic                   r_out_vld;
    logic                   n_out_vld;
    mthps_pkg::t_out_item   r_out;
    mthps_pkg::t_out_item   eval_result;
    logic                   in_is_close;
    logic                   advance;
    logic                   load_in;

    // The held item retires unless it is a closing item and the output
    // register is full and stalled.
    assign in_is_close = (r_in.req_type == mthps_pkg::REQ_CLOSE);
    assign advance     = r_in_vld && (!in_is_close || !r_out_vld || !i_stall);
    assign o_stall     = r_in_vld && !advance;
    assign load_in     = i_valid && !o_stall;
    assign n_in_vld    = load_in || (r_in_vld && !advance);

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    mthps_eval #(
        .NUM_STATIONS (NUM_STATIONS),
        .NUM_REGIONS  (NUM_REGIONS)
    ) u_eval (
        .i_cfg         (r_cfg),
        .i_a_mask      (r_a_mask),
        .i_c_mask      (r_c_mask),
        .i_region_mask (r_region_mask),
        .i_item        (r_in),
        .o_result      (eval_result)
    );

    // Configuration writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mthps_pkg::CFG_MOMENTUM_CUT:
                    n_cfg.momentum_cut_mev = i_cfg_wdata[mthps_pkg::MOM_W-1:0];
                mthps_pkg::CFG_MIN_STATIONS:
                    n_cfg.min_stations = i_cfg_wdata[mthps_pkg::MIN_ST_W-1:0];
                mthps_pkg::CFG_NO_OVERLAP:
                    n_cfg.no_overlap_enable = i_cfg_wdata[0];
                mthps_pkg::CFG_CALO_CHECK:
                    n_cfg.calo_check_enable = i_cfg_wdata[0];
                mthps_pkg::CFG_CHI2_CUT:
                    n_cfg.chi2_cut_q8 = i_cfg_wdata[mthps_pkg::CHI2_W-1:0];
                mthps_pkg::CFG_REGION_MODE:
                    n_cfg.region_mode = $signed(i_cfg_wdata[mthps_pkg::RMODE_W-1:0]);
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    // Hit pattern update, cleared once a closing item retires
    always_comb begin
        n_a_mask      = r_a_mask;
        n_c_mask      = r_c_mask;
        n_region_mask = r_region_mask;
        if (advance) begin
            if (in_is_close) begin
                n_a_mask      = '0;
                n_c_mask      = '0;
                n_region_mask = '0;
            end else if (r_in.hit_is_muon) begin
                for (int s = 0; s < NUM_STATIONS; s++) begin
                    if (int'(r_in.hit_station) == s) begin
                        if (r_in.hit_quarter < 2'd2) begin
                            n_a_mask[s] = 1'b1;
                        end else begin
                            n_c_mask[s] = 1'b1;
                        end
                    end
                end
                for (int r = 0; r < NUM_REGIONS; r++) begin
                    if (int'(r_in.hit_region) == r) begin
                        n_region_mask[r] = 1'b1;
                    end
                end
            end
        end
    end

    // Output register: load on a retiring closing item, hold while stalled
    always_comb begin
        if (advance && in_is_close) begin
            n_out_vld = 1'b1;
        end else begin
            n_out_vld = r_out_vld && i_stall;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.momentum_cut_mev  <= '0;
            r_cfg.min_stations      <= mthps_pkg::MIN_ST_RST;
            r_cfg.no_overlap_enable <= 1'b0;
            r_cfg.calo_check_enable <= 1'b0;
            r_cfg.chi2_cut_q8       <= '0;
            r_cfg.region_mode       <= mthps_pkg::RMODE_OFF;
            r_in_vld                <= 1'b0;
            r_out_vld               <= 1'b0;
            r_a_mask                <= '0;
            r_c_mask                <= '0;
            r_region_mask           <= '0;
        end else begin
            r_cfg         <= n_cfg;
            r_in_vld      <= n_in_vld;
            r_out_vld     <= n_out_vld;
            r_a_mask      <= n_a_mask;
            r_c_mask      <= n_c_mask;
            r_region_mask <= n_region_mask;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_in <= i_data;
        end
        if (advance && in_is_close) begin
            r_out <= eval_result;
        end
    end

endmodule

// ===== hdl/mthps_eval.sv =====
// ----------------------------------------------------------------------------
// mthps_eval
// Track cut evaluation: station counts and all selection cuts on one track.
// ----------------------------------------------------------------------------
module mthps_eval #(
    parameter int NUM_STATIONS = mthps_pkg::NUM_STATIONS_DEF,
    parameter int NUM_REGIONS  = mthps_pkg::NUM_REGIONS_DEF
) (
    input  mthps_pkg::t_cfg           i_cfg,
    input  logic [NUM_STATIONS-1:0]   i_a_mask,
    input  logic [NUM_STATIONS-1:0]   i_c_mask,
    input  logic [NUM_REGIONS-1:0]    i_region_mask,
    input  mthps_pkg::t_in_item       i_item,
    output mthps_pkg::t_out_item      o_result
);

    localparam int CNT_W = $clog2(NUM_STATIONS + 1);
    localparam int RCNT_W = $clog2(NUM_REGIONS + 1);
    localparam int CMP_W = (CNT_W + 1 > mthps_pkg::MIN_ST_W) ? CNT_W + 1 : mthps_pkg::MIN_ST_W;

    logic [CNT_W-1:0]               na;
    logic [CNT_W-1:0]               nc;
    logic [CMP_W-1:0]               na_x;
    logic [CMP_W-1:0]               nc_x;
    logic [CMP_W-1:0]               min_x;
    logic [RCNT_W-1:0]              nreg;
    logic                           region_ok;
    logic                           other_hit;
    logic                           want_hit;
    logic                           above_top;
    logic [1:0]                     top;
    logic                           mom_ok;
    logic                           count_ok;
    logic                           overlap_ok;
    logic                           calo_ok;
    logic                           chi2_ok;
    logic signed [mthps_pkg::RMODE_W-1:0] mode;

    // Count distinct stations per side and distinct regions
    always_comb begin
        na   = '0;
        nc   = '0;
        nreg = '0;
        for (int s = 0; s < NUM_STATIONS; s++) begin
            na = na + CNT_W'(i_a_mask[s]);
            nc = nc + CNT_W'(i_c_mask[s]);
        end
        for (int r = 0; r < NUM_REGIONS; r++) begin
            nreg = nreg + RCNT_W'(i_region_mask[r]);
        end
    end

    assign na_x  = CMP_W'(na);
    assign nc_x  = CMP_W'(nc);
    assign min_x = CMP_W'(i_cfg.min_stations);
    assign mode  = i_cfg.region_mode;

    // Region cut
    always_comb begin
        other_hit = 1'b0;
        want_hit  = 1'b0;
        above_top = 1'b0;
        if (mode >= mthps_pkg::RMODE_TENS_3) begin
            top = 2'd3;
        end else if (mode >= mthps_pkg::RMODE_TENS_2) begin
            top = 2'd2;
        end else begin
            top = 2'd1;
        end
        for (int r = 0; r < NUM_REGIONS; r++) begin
            if (i_region_mask[r]) begin
                if (r == int'(mode)) begin
                    want_hit = 1'b1;
                end else begin
                    other_hit = 1'b1;
                end
                if (r > int'(top)) begin
                    above_top = 1'b1;
                end
            end
        end
        if (mode >= 7'sd0 && mode <= mthps_pkg::RMODE_SINGLE_HI) begin
            region_ok = want_hit && !other_hit;
        end else if (mode == mthps_pkg::RMODE_ONE) begin
            region_ok = (nreg <= RCNT_W'(1));
        end else if (mode > mthps_pkg::RMODE_ONE && mode < mthps_pkg::RMODE_TENS_END) begin
            region_ok = !above_top;
        end else begin
            region_ok = 1'b1;
        end
    end

    assign mom_ok   = (i_cfg.momentum_cut_mev == '0) ||
                      (i_item.momentum_mev >= i_cfg.momentum_cut_mev);
    assign count_ok = ((na_x + nc_x) >= min_x);
    assign overlap_ok = !i_cfg.no_overlap_enable ||
                        (((na != '0) != (nc != '0)) && ((na_x > min_x) || (nc_x > min_x)));
    // Reject only when outside both the x and the y limits
    assign calo_ok  = !i_cfg.calo_check_enable ||
                      !(((i_item.calo_x_mm > mthps_pkg::CALO_X_LIMIT_MM) ||
                         (i_item.calo_x_mm < -mthps_pkg::CALO_X_LIMIT_MM)) &&
                        ((i_item.calo_y_mm > mthps_pkg::CALO_Y_LIMIT_MM) ||
                         (i_item.calo_y_mm < -mthps_pkg::CALO_Y_LIMIT_MM)));
    assign chi2_ok  = (i_cfg.chi2_cut_q8 == '0) ||
                      (i_item.chi2_per_dof_q8 <= i_cfg.chi2_cut_q8);

    always_comb begin
        o_result.track_selected = mom_ok && region_ok && count_ok && overlap_ok &&
                                  calo_ok && chi2_ok;
        // Saturate reported counts at the output width
        o_result.a_side_stations = (na_x > CMP_W'(mthps_pkg::OUT_CNT_MAX)) ?
                                   mthps_pkg::OUT_CNT_MAX : mthps_pkg::OUT_CNT_W'(na_x);
        o_result.c_side_stations = (nc_x > CMP_W'(mthps_pkg::OUT_CNT_MAX)) ?
                                   mthps_pkg::OUT_CNT_MAX : mthps_pkg::OUT_CNT_W'(nc_x);
    end

endmodule

// ===== hdl/mthps_checker.sv =====
// ----------------------------------------------------------------------------
// mthps_checker
// Port-level checks of the muon track hit-pattern selector.
// ----------------------------------------------------------------------------
module mthps_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  mthps_pkg::t_in_item   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  mthps_pkg::t_out_item  i_out_data
);

    logic in_acc;
    logic in_close;

    assign in_acc   = i_in_valid && !i_in_stall;
    assign in_close = (i_in_data.req_type == mthps_pkg::REQ_CLOSE);

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // A closing item yields a result through the input and output registers when the output is free
    a_close_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && in_close ##1 (!i_out_valid || !i_out_stall) |=> i_out_valid)
        else $error("closing item produced no result");

    // A hit item never produces a result
    a_hit_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !in_close ##1 !i_out_valid |=> !i_out_valid)
        else $error("hit item produced a result");

endmodule

bind muon_track_hit_pattern_selector_core mthps_checker u_mthps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_valid),
    .i_in_stall  (o_stall),
    .i_in_data   (i_data),
    .i_out_valid (o_valid),
    .i_out_stall (i_stall),
    .i_out_data  (o_data)
);
